/* rtl/fpba_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the block allocator
// Table sizing, field widths, policy and operation codes, and the item
// and controller interface structures.
// ---------------------------------------------------------------------------
package fpba_pkg;

    localparam int POOL_BYTES = 32768;
    localparam int SLOT_BYTES = 128;
    localparam int ENTRIES    = 256;

    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 15;
    localparam int INDEX_W  = 8;
    localparam int MODE_W   = 2;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int OFFS_W = $clog2(ENTRIES * SLOT_BYTES + 1);
    localparam int CMP_W  = (OFFS_W > OFFSET_W) ? OFFS_W : OFFSET_W;
    localparam int SUM_W  = ((OFFS_W > 20) ? OFFS_W : 20) + 2;

    localparam logic OP_FREE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef struct packed {
        logic                op;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] free_offset;
    } fpba_in_t;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] block_offset;
        logic [INDEX_W-1:0]  entry_index;
        logic                freed;
        logic [SIZE_W-1:0]   bytes_used;
    } fpba_out_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } fpba_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } fpba_status_t;

endpackage
`default_nettype wire

/* rtl/fpba_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fpba_ctrl: allocator sequencer
// Accepts one item, runs the table scan in the datapath, and commits the
// result once the output register is free.
// ---------------------------------------------------------------------------
module fpba_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output fpba_pkg::fpba_cmd_t         cmd,
    input  wire fpba_pkg::fpba_status_t status
);
    import fpba_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/fpba_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fpba_datapath: block table, scan pipeline and output register
// Holds the size memories, in-use flags, counters and the policy register,
// evaluates one table entry per cycle, and applies the chosen update.
// ---------------------------------------------------------------------------
module fpba_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fpba_pkg::MODE_W-1:0]   cfg_wr_data,
    input  wire fpba_pkg::fpba_in_t            in_data,
    input  wire fpba_pkg::fpba_cmd_t           cmd,
    output fpba_pkg::fpba_status_t             status,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output fpba_pkg::fpba_out_t                out_data
);
    import fpba_pkg::*;

    logic [SIZE_W-1:0] blk_mem  [0:ENTRIES-1];
    logic [SIZE_W-1:0] used_mem [0:ENTRIES-1];
    logic [SIZE_W-1:0] blk_rd_reg;
    logic [SIZE_W-1:0] used_rd_reg;

    logic [ENTRIES-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SIZE_W-1:0]  used_reg, used_next;
    logic [MODE_W-1:0]  fit_mode_reg, fit_mode_next;

    logic                op_reg, op_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic [OFFSET_W-1:0] foff_reg, foff_next;

    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic [OFFS_W-1:0] issue_off_reg, issue_off_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    logic [OFFS_W-1:0] eval_off_reg, eval_off_next;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    logic [OFFS_W-1:0] pick_off_reg, pick_off_next;
    logic [SIZE_W-1:0] pick_size_reg, pick_size_next;
    logic [SIZE_W-1:0] pick_used_reg, pick_used_next;

    logic      out_valid_reg, out_valid_next;
    fpba_out_t out_data_reg, out_data_next;

    logic              issue_done;
    logic              issue_fire;
    logic              eval_in_use;
    logic              take;
    logic [SUM_W-1:0]  append_sum;
    logic              append_ok;
    logic [SIZE_W:0]   add_sum;
    logic [SIZE_W-1:0] add_sat;
    logic [SIZE_W-1:0] sub_sat;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    assign issue_done  = (issue_idx_reg == count_reg);
    assign issue_fire  = cmd.scan && !issue_done;
    assign eval_in_use = in_use_reg[eval_idx_reg];

    assign status.scan_done = issue_done && !eval_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign append_sum = SUM_W'(issue_off_reg) + SUM_W'(req_reg) + SUM_W'(used_reg);
    assign append_ok  = (count_reg < CNT_W'(ENTRIES)) && (append_sum <= SUM_W'(POOL_BYTES));
    assign add_sum    = {1'b0, used_reg} + {1'b0, req_reg};
    assign add_sat    = add_sum[SIZE_W] ? {SIZE_W{1'b1}} : add_sum[SIZE_W-1:0];
    assign sub_sat    = (used_reg >= pick_used_reg) ? (used_reg - pick_used_reg) : '0;

    always_comb
    begin
        take = 1'b0;
        if (eval_valid_reg)
        begin
            if (op_reg == OP_FREE)
            begin
                take = eval_in_use && !found_reg &&
                       (CMP_W'(eval_off_reg) == CMP_W'(foff_reg));
            end
            else if (!eval_in_use && (blk_rd_reg >= req_reg))
            begin
                if (!found_reg)
                begin
                    take = 1'b1;
                end
                else
                begin
                    case (fit_mode_reg)
                        MODE_BEST:  take = (blk_rd_reg < pick_size_reg);
                        MODE_WORST: take = (blk_rd_reg > pick_size_reg);
                        default:    take = 1'b0;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        in_use_next     = in_use_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        fit_mode_next   = fit_mode_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        foff_next       = foff_reg;
        issue_idx_next  = issue_idx_reg;
        issue_off_next  = issue_off_reg;
        eval_valid_next = issue_fire;
        eval_idx_next   = eval_idx_reg;
        eval_off_next   = eval_off_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_off_next   = pick_off_reg;
        pick_size_next  = pick_size_reg;
        pick_used_next  = pick_used_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_waddr       = pick_idx_reg;

        if (cfg_wr_en)
        begin
            fit_mode_next = cfg_wr_data;
        end

        if (cmd.load)
        begin
            op_next        = in_data.op;
            req_next       = in_data.request_size;
            foff_next      = in_data.free_offset;
            issue_idx_next = '0;
            issue_off_next = '0;
            found_next     = 1'b0;
        end

        if (issue_fire)
        begin
            issue_idx_next = issue_idx_reg + CNT_W'(1);
            issue_off_next = issue_off_reg + OFFS_W'(SLOT_BYTES);
            eval_idx_next  = issue_idx_reg[IDX_W-1:0];
            eval_off_next  = issue_off_reg;
        end

        if (take)
        begin
            found_next     = 1'b1;
            pick_idx_next  = eval_idx_reg;
            pick_off_next  = eval_off_reg;
            pick_size_next = blk_rd_reg;
            pick_used_next = used_rd_reg;
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (op_reg == OP_FREE)
            begin
                if (found_reg)
                begin
                    in_use_next[pick_idx_reg] = 1'b0;
                    used_next                 = sub_sat;
                    out_data_next.entry_index = INDEX_W'(pick_idx_reg);
                    out_data_next.freed       = 1'b1;
                end
                out_data_next.bytes_used = (found_reg) ? sub_sat : used_reg;
            end
            else if (found_reg)
            begin
                in_use_next[pick_idx_reg]  = 1'b1;
                used_next                  = add_sat;
                mem_we                     = 1'b1;
                out_data_next.granted      = 1'b1;
                out_data_next.block_offset = OFFSET_W'(pick_off_reg);
                out_data_next.entry_index  = INDEX_W'(pick_idx_reg);
                out_data_next.bytes_used   = add_sat;
            end
            else if (append_ok)
            begin
                in_use_next[count_reg[IDX_W-1:0]] = 1'b1;
                count_next                 = count_reg + CNT_W'(1);
                used_next                  = add_sat;
                mem_we                     = 1'b1;
                mem_waddr                  = count_reg[IDX_W-1:0];
                out_data_next.granted      = 1'b1;
                out_data_next.block_offset = OFFSET_W'(issue_off_reg);
                out_data_next.entry_index  = INDEX_W'(count_reg);
                out_data_next.bytes_used   = add_sat;
            end
            else
            begin
                out_data_next.bytes_used = used_reg;
            end
        end
    end

    // Used size is written on every grant; block size is written only when
    // a new entry is appended.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[mem_waddr] <= req_reg;
            if (mem_waddr == count_reg[IDX_W-1:0] && !found_reg)
            begin
                blk_mem[mem_waddr] <= req_reg;
            end
        end
        if (issue_fire)
        begin
            blk_rd_reg  <= blk_mem[issue_idx_reg[IDX_W-1:0]];
            used_rd_reg <= used_mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            count_reg      <= '0;
            used_reg       <= '0;
            fit_mode_reg   <= MODE_FIRST;
            issue_idx_reg  <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_use_reg     <= in_use_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            fit_mode_reg   <= fit_mode_next;
            issue_idx_reg  <= issue_idx_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        req_reg       <= req_next;
        foff_reg      <= foff_next;
        issue_off_reg <= issue_off_next;
        eval_idx_reg  <= eval_idx_next;
        eval_off_reg  <= eval_off_next;
        pick_idx_reg  <= pick_idx_next;
        pick_off_reg  <= pick_off_next;
        pick_size_reg <= pick_size_next;
        pick_used_reg <= pick_used_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* rtl/fit_policy_block_allocator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fit_policy_block_allocator: block-table allocator with selectable policy
// Serves allocate and free requests against a table of blocks using first,
// best or worst fit, appending new blocks while the table and the pool have room.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   in_data (op, request_size, free_offset)
//  out      output     out_valid / out_stall out_data (granted ... bytes_used)
//  cfg      input      cfg_wr_en             cfg_wr_data (fit_mode)
//
//  An item passes from acceptance through the table scan to its result in the
//  output register; the scan reads one table entry per cycle from the size
//  memories. Reset clears the in-use flags, counters and policy at once, so the
//  block is ready right after reset. A result held by out_stall blocks only the
//  commit of the following item, not its acceptance or scan.
// ---------------------------------------------------------------------------
module fit_policy_block_allocator
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fpba_pkg::MODE_W-1:0] cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire fpba_pkg::fpba_in_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output fpba_pkg::fpba_out_t              out_data
);
    import fpba_pkg::*;

    fpba_cmd_t    cmd;
    fpba_status_t status;

    fpba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    fpba_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire
